@@ hw/rtl/turn_indicator_controller_top_assert.svh @@
// Assertion macros for the turn indicator controller checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef TURN_INDICATOR_CONTROLLER_TOP_ASSERT_SVH
`define TURN_INDICATOR_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, ignored during reset
`define TIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored during reset
`define TIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tic_pkg.sv @@
// Shared types, register indexes, reset values and state codes for the
// turn indicator controller. No dependencies.
package tic_pkg;

  typedef struct packed {
    logic              tick;
    logic              fresh_data;
    logic              standby;
    logic              hazard_request;
    logic signed [7:0] steer_signed;
    logic [6:0]        steer_magnitude;
    logic [6:0]        throttle_magnitude;
  } tic_in_t;

  typedef struct packed {
    logic left_on;
    logic right_on;
    logic hazard_on;
    logic blink_phase;
  } tic_out_t;

  typedef struct packed {
    logic [6:0]  centre_low;
    logic [6:0]  centre_high;
    logic [6:0]  blink_level;
    logic [15:0] idle_ticks;
    logic [15:0] off_ticks;
    logic [15:0] light_ticks;
    logic [15:0] dark_ticks;
    logic [1:0]  indicator_mode;
  } tic_cfg_t;

  typedef struct packed {
    logic [3:0]  mode_state;
    logic [15:0] hold_timer;
    logic [15:0] phase_counter;
    logic        phase_lit;
    logic        left_active;
    logic        right_active;
    logic        hazard_active;
  } tic_state_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_CENTRE_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLINK_LEVEL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TICKS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_TICKS   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_TICKS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DARK_TICKS  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_IND_MODE    = 3'd7;

  localparam tic_cfg_t CFG_RESET = '{
    centre_low:     7'd8,
    centre_high:    7'd10,
    blink_level:    7'd50,
    idle_ticks:     16'd100,
    off_ticks:      16'd100,
    light_ticks:    16'd30,
    dark_ticks:     16'd30,
    indicator_mode: 2'd0
  };

  localparam logic [3:0] ST_NOT_NEUTRAL  = 4'd0;
  localparam logic [3:0] ST_NEUTRAL_WAIT = 4'd1;
  localparam logic [3:0] ST_ARMED        = 4'd2;
  localparam logic [3:0] ST_ARMED_LEFT   = 4'd3;
  localparam logic [3:0] ST_ARMED_RIGHT  = 4'd4;
  localparam logic [3:0] ST_LEFT         = 4'd5;
  localparam logic [3:0] ST_LEFT_WAIT    = 4'd6;
  localparam logic [3:0] ST_RIGHT        = 4'd7;
  localparam logic [3:0] ST_RIGHT_WAIT   = 4'd8;

  localparam tic_state_t STATE_RESET = '{
    mode_state:    ST_NOT_NEUTRAL,
    hold_timer:    16'd0,
    phase_counter: 16'd0,
    phase_lit:     1'b0,
    left_active:   1'b0,
    right_active:  1'b0,
    hazard_active: 1'b0
  };

endpackage

@@ hw/rtl/turn_indicator_controller_top.sv @@
// Turn indicator controller top level: config registers, state registers
// and result register around tic_step. Depends on tic_pkg and tic_step.
// The result is registered: result_valid rises in the cycle after an input beat is accepted.
// Throughput: one beat per cycle while item_stall is low; the whole update is one registered pass.
// Input stalls only while a result is held and the output is stalled.
// Reset (rst, synchronous) restores register defaults, resets the state register and clears result_valid.
module turn_indicator_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  tic_pkg::tic_in_t               item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output tic_pkg::tic_out_t              result,
  input  logic                           cfg_we,
  input  logic [tic_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tic_pkg::CfgDataW-1:0]   cfg_data
);
  import tic_pkg::*;

  tic_cfg_t   cfg;
  tic_state_t state;
  tic_state_t state_next;
  logic       accept;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTRE_LOW:  cfg.centre_low     <= cfg_data[6:0];
        REG_CENTRE_HIGH: cfg.centre_high    <= cfg_data[6:0];
        REG_BLINK_LEVEL: cfg.blink_level    <= cfg_data[6:0];
        REG_IDLE_TICKS:  cfg.idle_ticks     <= cfg_data;
        REG_OFF_TICKS:   cfg.off_ticks      <= cfg_data;
        REG_LIGHT_TICKS: cfg.light_ticks    <= cfg_data;
        REG_DARK_TICKS:  cfg.dark_ticks     <= cfg_data;
        REG_IND_MODE:    cfg.indicator_mode <= cfg_data[1:0];
        default:         cfg                <= cfg;
      endcase
    end
  end

  tic_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (item),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= STATE_RESET;
      result_valid <= 1'b0;
    end else if (accept) begin
      state        <= state_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.left_on     <= state_next.left_active;
      result.right_on    <= state_next.right_active;
      result.hazard_on   <= state_next.hazard_active;
      result.blink_phase <= state_next.phase_lit;
    end
  end

endmodule

@@ hw/rtl/tic_step.sv @@
// Next-state logic for one beat: hazard change, tick, then the indicator
// state machine. Depends on tic_pkg.
module tic_step (
  input  tic_pkg::tic_cfg_t   cfg,
  input  tic_pkg::tic_state_t cur,
  input  tic_pkg::tic_in_t    item,
  output tic_pkg::tic_state_t nxt
);
  import tic_pkg::*;

  logic signed [8:0] st9;
  logic signed [8:0] bl9;
  logic signed [8:0] nbl9;
  logic              ignore_th;
  logic              th_neutral;

  assign st9        = {item.steer_signed[7], item.steer_signed};
  assign bl9        = {2'b00, cfg.blink_level};
  assign nbl9       = 9'sd0 - bl9;
  assign ignore_th  = cfg.indicator_mode[0];
  assign th_neutral = ignore_th || (item.throttle_magnitude <= cfg.centre_high);

  always_comb begin
    nxt = cur;

    if (item.hazard_request != nxt.hazard_active) begin
      if (!(nxt.left_active || nxt.right_active || nxt.hazard_active)) begin
        nxt.phase_counter = cfg.light_ticks;
        nxt.phase_lit     = 1'b1;
      end
      nxt.hazard_active = item.hazard_request;
    end

    if (item.tick) begin
      if (nxt.hold_timer != 16'd0) begin
        nxt.hold_timer = nxt.hold_timer - 16'd1;
      end
      if (nxt.phase_counter == 16'd0) begin
        nxt.phase_lit     = !nxt.phase_lit;
        nxt.phase_counter = nxt.phase_lit ? cfg.light_ticks : cfg.dark_ticks;
      end else begin
        nxt.phase_counter = nxt.phase_counter - 16'd1;
      end
    end

    if (item.fresh_data && !item.standby && !cfg.indicator_mode[1]) begin
      unique case (cur.mode_state)
        ST_NEUTRAL_WAIT: begin
          if (item.steer_magnitude > cfg.centre_high || !th_neutral) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (nxt.hold_timer == 16'd0) begin
            nxt.mode_state = ST_ARMED;
          end
        end
        ST_ARMED: begin
          if (!th_neutral) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (item.steer_magnitude >= cfg.blink_level) begin
            nxt.hold_timer = cfg.idle_ticks;
            nxt.mode_state = item.steer_signed[7] ? ST_ARMED_LEFT : ST_ARMED_RIGHT;
          end
        end
        ST_ARMED_LEFT: begin
          if (!th_neutral) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 > nbl9) begin
            nxt.mode_state = ST_ARMED;
          end else if (nxt.hold_timer == 16'd0) begin
            if (!(nxt.left_active || nxt.right_active || nxt.hazard_active)) begin
              nxt.phase_counter = cfg.light_ticks;
              nxt.phase_lit     = 1'b1;
            end
            nxt.mode_state   = ST_LEFT;
            nxt.left_active  = 1'b1;
            nxt.right_active = 1'b0;
          end
        end
        ST_ARMED_RIGHT: begin
          if (!th_neutral) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 < bl9) begin
            nxt.mode_state = ST_ARMED;
          end else if (nxt.hold_timer == 16'd0) begin
            if (!(nxt.left_active || nxt.right_active || nxt.hazard_active)) begin
              nxt.phase_counter = cfg.light_ticks;
              nxt.phase_lit     = 1'b1;
            end
            nxt.mode_state   = ST_RIGHT;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b1;
          end
        end
        ST_LEFT: begin
          if (st9 > bl9) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 > nbl9) begin
            nxt.hold_timer = cfg.off_ticks;
            nxt.mode_state = ST_LEFT_WAIT;
          end
        end
        ST_LEFT_WAIT: begin
          if (st9 > bl9) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 < nbl9) begin
            nxt.mode_state = ST_LEFT;
          end else if (nxt.hold_timer == 16'd0) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end
        end
        ST_RIGHT: begin
          if (st9 < nbl9) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 < bl9) begin
            nxt.hold_timer = cfg.off_ticks;
            nxt.mode_state = ST_RIGHT_WAIT;
          end
        end
        ST_RIGHT_WAIT: begin
          if (st9 < nbl9) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end else if (st9 > bl9) begin
            nxt.mode_state = ST_RIGHT;
          end else if (nxt.hold_timer == 16'd0) begin
            nxt.mode_state   = ST_NOT_NEUTRAL;
            nxt.left_active  = 1'b0;
            nxt.right_active = 1'b0;
          end
        end
        default: begin
          // not neutral, and unused codes
          if (item.steer_magnitude <= cfg.centre_low &&
              (ignore_th || item.throttle_magnitude <= cfg.centre_low)) begin
            nxt.hold_timer = cfg.idle_ticks;
            nxt.mode_state = ST_NEUTRAL_WAIT;
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/tic_checker.sv @@
// Port-level checker for turn_indicator_controller_top, bound to it below.
// Depends on tic_pkg and turn_indicator_controller_top_assert.svh.
`include "turn_indicator_controller_top_assert.svh"

module tic_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input tic_pkg::tic_in_t             item,
  input logic                         result_valid,
  input logic                         result_stall,
  input tic_pkg::tic_out_t            result,
  input logic                         cfg_we,
  input logic [tic_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [tic_pkg::CfgDataW-1:0] cfg_data
);

  logic item_beat;
  logic cfg_seen;

  assign item_beat = item_valid && !item_stall;
  assign cfg_seen  = cfg_we && (cfg_index == cfg_index) && (cfg_data == cfg_data);

  `TIC_ASSERT_NOW(a_one_side, result_valid, !(result.left_on && result.right_on), "left and right both on")
  `TIC_ASSERT_NXT(a_beat_gives_result, item_beat, result_valid, "accepted beat gave no result")
  `TIC_ASSERT_NXT(a_hazard_follows, item_beat, result.hazard_on == $past(item.hazard_request), "hazard_on does not follow request")
  `TIC_ASSERT_NXT(a_result_holds, result_valid && result_stall && !cfg_seen, result_valid && $stable(result), "stalled result changed")

endmodule

bind turn_indicator_controller_top tic_checker u_tic_checker (.*);

@@ tb/turn_indicator_controller_checker.sv @@
`timescale 1ns / 100ps
// Lamp checker for turn_indicator_controller_top: mirrors register writes, predicts a
// result beat for every accepted item beat and compares field by field. Needs tic_pkg.
module turn_indicator_controller_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  tic_pkg::tic_in_t             item,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  tic_pkg::tic_out_t            result,
  input  logic                         cfg_we,
  input  logic [tic_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tic_pkg::CfgDataW-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import tic_pkg::*;

  tic_cfg_t   regs = CFG_RESET;
  tic_state_t lamps = STATE_RESET;
  tic_out_t   lamp_q[$];
  tic_out_t   want;
  int         fails = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic tic_state_t next_lamps(tic_state_t s, tic_cfg_t c, tic_in_t it);
    int   st, bl;
    logic th_ok, go_off, go_left, go_right;
    st       = $signed(it.steer_signed);
    bl       = c.blink_level;
    th_ok    = c.indicator_mode[0] || (it.throttle_magnitude <= c.centre_high);
    go_off   = 1'b0;
    go_left  = 1'b0;
    go_right = 1'b0;

    if (it.hazard_request != s.hazard_active) begin
      if (!(s.left_active || s.right_active || s.hazard_active)) begin
        s.phase_counter = c.light_ticks;
        s.phase_lit     = 1'b1;
      end
      s.hazard_active = it.hazard_request;
    end

    if (it.tick) begin
      if (s.hold_timer != 16'd0) s.hold_timer = s.hold_timer - 16'd1;
      if (s.phase_counter == 16'd0) begin
        s.phase_lit     = !s.phase_lit;
        s.phase_counter = s.phase_lit ? c.light_ticks : c.dark_ticks;
      end else begin
        s.phase_counter = s.phase_counter - 16'd1;
      end
    end

    // bit 1 of the mode disables the automatic logic
    if (it.fresh_data && !it.standby && !c.indicator_mode[1]) begin
      case (s.mode_state)
        ST_NEUTRAL_WAIT: begin
          if (it.steer_magnitude > c.centre_high || !th_ok) go_off = 1'b1;
          else if (s.hold_timer == 16'd0) s.mode_state = ST_ARMED;
        end
        ST_ARMED: begin
          if (!th_ok) begin
            go_off = 1'b1;
          end else if (it.steer_magnitude >= c.blink_level) begin
            s.hold_timer = c.idle_ticks;
            s.mode_state = (st < 0) ? ST_ARMED_LEFT : ST_ARMED_RIGHT;
          end
        end
        ST_ARMED_LEFT: begin
          if (!th_ok) go_off = 1'b1;
          else if (st > -bl) s.mode_state = ST_ARMED;
          else if (s.hold_timer == 16'd0) go_left = 1'b1;
        end
        ST_ARMED_RIGHT: begin
          if (!th_ok) go_off = 1'b1;
          else if (st < bl) s.mode_state = ST_ARMED;
          else if (s.hold_timer == 16'd0) go_right = 1'b1;
        end
        ST_LEFT: begin
          if (st > bl) begin
            go_off = 1'b1;
          end else if (st > -bl) begin
            s.hold_timer = c.off_ticks;
            s.mode_state = ST_LEFT_WAIT;
          end
        end
        ST_LEFT_WAIT: begin
          if (st > bl) go_off = 1'b1;
          else if (st < -bl) s.mode_state = ST_LEFT;
          else if (s.hold_timer == 16'd0) go_off = 1'b1;
        end
        ST_RIGHT: begin
          if (st < -bl) begin
            go_off = 1'b1;
          end else if (st < bl) begin
            s.hold_timer = c.off_ticks;
            s.mode_state = ST_RIGHT_WAIT;
          end
        end
        ST_RIGHT_WAIT: begin
          if (st < -bl) go_off = 1'b1;
          else if (st > bl) s.mode_state = ST_RIGHT;
          else if (s.hold_timer == 16'd0) go_off = 1'b1;
        end
        default: begin
          // not neutral, and any unused code
          if (it.steer_magnitude <= c.centre_low &&
              (c.indicator_mode[0] || it.throttle_magnitude <= c.centre_low)) begin
            s.hold_timer = c.idle_ticks;
            s.mode_state = ST_NEUTRAL_WAIT;
          end
        end
      endcase
    end

    if (go_off) begin
      s.mode_state   = ST_NOT_NEUTRAL;
      s.left_active  = 1'b0;
      s.right_active = 1'b0;
    end
    if (go_left || go_right) begin
      if (!(s.left_active || s.right_active || s.hazard_active)) begin
        s.phase_counter = c.light_ticks;
        s.phase_lit     = 1'b1;
      end
      s.mode_state   = go_left ? ST_LEFT : ST_RIGHT;
      s.left_active  = go_left;
      s.right_active = go_right;
    end
    return s;
  endfunction

  task automatic cmp_bit(input string field, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      fails++;
      $display("%0t: %s expected %0b got %0b", $time, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs  = CFG_RESET;
      lamps = STATE_RESET;
      lamp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTRE_LOW:  regs.centre_low     = cfg_data[6:0];
          REG_CENTRE_HIGH: regs.centre_high    = cfg_data[6:0];
          REG_BLINK_LEVEL: regs.blink_level    = cfg_data[6:0];
          REG_IDLE_TICKS:  regs.idle_ticks     = cfg_data;
          REG_OFF_TICKS:   regs.off_ticks      = cfg_data;
          REG_LIGHT_TICKS: regs.light_ticks    = cfg_data;
          REG_DARK_TICKS:  regs.dark_ticks     = cfg_data;
          REG_IND_MODE:    regs.indicator_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      // older beats leave before this edge's item is predicted
      if (result_valid && !result_stall) begin
        if (lamp_q.size() == 0) begin
          fails++;
          $display("%0t: result beat expected none got %b", $time, result);
        end else begin
          want = lamp_q.pop_front();
          cmp_bit("left_on", want.left_on, result.left_on);
          cmp_bit("right_on", want.right_on, result.right_on);
          cmp_bit("hazard_on", want.hazard_on, result.hazard_on);
          cmp_bit("blink_phase", want.blink_phase, result.blink_phase);
        end
      end
      if (item_valid && !item_stall) begin
        lamps = next_lamps(lamps, regs, item);
        lamp_q.push_back({lamps.left_active, lamps.right_active,
                          lamps.hazard_active, lamps.phase_lit});
      end
    end
    pending    <= lamp_q.size();
    fail_count <= fails;
  end

endmodule

@@ tb/turn_indicator_controller_top_tb.sv @@
`timescale 1ns / 100ps
// Top of the turn indicator controller bench: clock, reset, register setup and item
// beats with random gaps and stalls. Needs tic_pkg, the block and the lamp checker.
module turn_indicator_controller_top_tb;
  import tic_pkg::*;

  localparam int unsigned ITEM_GOAL   = 1900;
  localparam int          PHASE_ITEMS = 120;
  localparam int          ITEM_W      = $bits(tic_in_t);

  typedef enum int {CFG_SMALL, CFG_ZERO, CFG_FULL, CFG_DEFAULT} cfg_kind_e;
  typedef enum int {MODE_AUTO, MODE_NO_THROTTLE, MODE_MANUAL, MODE_MANUAL_ALT} ind_mode_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  tic_in_t             item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  tic_out_t            result;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  fail_count;
  int                  pending;

  int unsigned sent = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          haz_level = 1'b0;
  int          cl, ch, bl, idle_t, off_t, light_t, dark_t;
  ind_mode_e   ind_mode = MODE_AUTO;

  turn_indicator_controller_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  turn_indicator_controller_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("turn_indicator_controller_top_tb NOT OK");
    $finish;
  end

  // result side: random stall before each beat
  initial begin : sink
    int unsigned hold;
    forever begin
      hold = sink_calm ? 0 : $urandom_range(8);
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  function automatic tic_in_t mk(input bit tk, fr, sb, hz, input int st, sm, tm);
    tic_in_t it;
    it.tick               = tk;
    it.fresh_data         = fr;
    it.standby            = sb;
    it.hazard_request     = hz;
    it.steer_signed       = 8'(st);
    it.steer_magnitude    = 7'(sm);
    it.throttle_magnitude = 7'(tm);
    return it;
  endfunction

  task automatic send(input tic_in_t it);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(8);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic wait_drained();
    int spins;
    item_valid <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (pending != 0 && spins < 4000);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    @(posedge clk);
  endtask

  task automatic apply_cfg();
    write_reg(REG_CENTRE_LOW, cl);
    write_reg(REG_CENTRE_HIGH, ch);
    write_reg(REG_BLINK_LEVEL, bl);
    write_reg(REG_IDLE_TICKS, idle_t);
    write_reg(REG_OFF_TICKS, off_t);
    write_reg(REG_LIGHT_TICKS, light_t);
    write_reg(REG_DARK_TICKS, dark_t);
    write_reg(REG_IND_MODE, ind_mode);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_cfg(input cfg_kind_e kind);
    int unsigned r;
    case (kind)
      CFG_ZERO: begin
        cl = 0; ch = 0; bl = 0;
        idle_t = 0; off_t = 0; light_t = 0; dark_t = 0;
      end
      CFG_FULL: begin
        cl = 100; ch = 100; bl = 100;
        idle_t = 65535; off_t = 65535; light_t = 65535; dark_t = 65535;
      end
      CFG_DEFAULT: begin
        cl      = CFG_RESET.centre_low;
        ch      = CFG_RESET.centre_high;
        bl      = CFG_RESET.blink_level;
        idle_t  = CFG_RESET.idle_ticks;
        off_t   = CFG_RESET.off_ticks;
        light_t = CFG_RESET.light_ticks;
        dark_t  = CFG_RESET.dark_ticks;
      end
      default: begin
        cl      = $urandom_range(20);
        ch      = $urandom_range(25);
        bl      = $urandom_range(100, 1);
        idle_t  = $urandom_range(6);
        off_t   = $urandom_range(6);
        light_t = $urandom_range(5);
        dark_t  = $urandom_range(5);
      end
    endcase
    r = $urandom_range(9);
    if (r < 5) ind_mode = MODE_AUTO;
    else if (r < 8) ind_mode = MODE_NO_THROTTLE;
    else if (r == 8) ind_mode = MODE_MANUAL;
    else ind_mode = MODE_MANUAL_ALT;
  endtask

  // steering held in a magnitude band until enough ticks have passed or 40 items have been sent
  task automatic hold_steer(input int ticks, input int lo, input int hi, input int side);
    int      got, n, mag, sgn, sm, tm, thr_hi;
    tic_in_t it;
    got = 0;
    n   = 0;
    if (hi < lo) hi = lo;
    thr_hi = (cl < ch) ? cl : ch;
    do begin
      if ($urandom_range(39) == 0) haz_level = !haz_level;
      mag = $urandom_range(hi, lo);
      sgn = (side != 0) ? side : ($urandom_range(1) ? 1 : -1);
      sm  = ($urandom_range(24) == 0) ? $urandom_range(127) : mag;
      if (ind_mode == MODE_NO_THROTTLE) tm = $urandom_range(127);
      else tm = ($urandom_range(24) == 0) ? $urandom_range(127) : $urandom_range(thr_hi);
      it = mk($urandom_range(3) != 0, $urandom_range(19) != 0, $urandom_range(29) == 0,
              haz_level, sgn * mag, sm, tm);
      send(it);
      n++;
      if (it.tick) got++;
    end while (got < ticks && n < 40);
  endtask

  task automatic turn_scenario();
    int side, calm_hi, back_hi;
    calm_hi = (cl < ch) ? cl : ch;
    back_hi = (bl > 0) ? bl - 1 : 0;
    side    = $urandom_range(1) ? 1 : -1;
    hold_steer(idle_t + $urandom_range(3, 1), 0, calm_hi, 0);
    hold_steer(idle_t + $urandom_range(3, 1), bl, 100, side);
    hold_steer($urandom_range(3), bl, 100, side);
    case ($urandom_range(2))
      0: hold_steer(off_t + $urandom_range(3, 1), 0, back_hi, 0);
      1: hold_steer($urandom_range(2, 1), bl + 1, 110, -side);
      default: begin
        hold_steer($urandom_range(2, 1), 0, back_hi, 0);
        hold_steer($urandom_range(3, 1), bl + 1, 110, side);
      end
    endcase
  endtask

  initial begin : stim
    int        phase, start, noise_n;
    cfg_kind_e kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: blink flag flips from zero, hazard resyncs the phase
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(0, 1, 0, 1, 0, 0, 0));
    wait_drained();

    cl = 8; ch = 10; bl = 50; idle_t = 1; off_t = 1; light_t = 1; dark_t = 0;
    ind_mode = MODE_AUTO;
    apply_cfg();
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(0, 1, 0, 0, 0, 0, 127));
    send(mk(1, 1, 0, 0, -8, 8, 8));
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(1, 1, 0, 0, -100, 100, 0));
    send(mk(1, 1, 0, 0, -128, 100, 0));
    send(mk(0, 1, 1, 0, 127, 127, 0));
    send(mk(1, 0, 0, 0, 127, 127, 0));
    send(mk(0, 1, 0, 1, -100, 100, 100));
    send(mk(1, 1, 0, 1, 0, 0, 0));
    send(mk(0, 1, 0, 0, -60, 60, 0));
    send(mk(1, 1, 0, 0, 10, 10, 0));
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(1, 1, 0, 0, 0, 0, 0));
    send(mk(1, 1, 0, 0, 100, 100, 0));
    send(mk(1, 1, 0, 0, 30, 100, 0));
    send(mk(1, 1, 0, 0, 127, 127, 0));
    send(mk(1, 1, 0, 0, 100, 100, 0));
    send(mk(0, 1, 0, 0, -100, 100, 0));
    send(mk(1, 1, 1, 1, -127, 0, 127));
    send(mk(1, 1, 0, 0, 0, 127, 0));
    wait_drained();

    phase = 0;
    while (sent < ITEM_GOAL) begin
      phase++;
      case (phase % 8)
        1: kind = CFG_ZERO;
        2: kind = CFG_FULL;
        3: kind = CFG_DEFAULT;
        default: kind = CFG_SMALL;
      endcase
      pick_cfg(kind);
      src_calm  = ($urandom_range(3) == 0);
      sink_calm = ($urandom_range(3) == 0);
      apply_cfg();
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        if ($urandom_range(9) < 7) begin
          turn_scenario();
        end else begin
          noise_n = $urandom_range(8, 1);
          repeat (noise_n) send(tic_in_t'(ITEM_W'($urandom)));
        end
      end
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("turn_indicator_controller_top_tb OK");
    end else begin
      $display("turn_indicator_controller_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tic_pkg.sv
hw/rtl/tic_step.sv
hw/rtl/turn_indicator_controller_top.sv
hw/rtl/tic_checker.sv
tb/turn_indicator_controller_checker.sv
tb/turn_indicator_controller_top_tb.sv
